>>> src/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg: shared types and constants for the shortest hop count block
// Holds the request and result payloads, the operation codes and the
// command group that drives the adjacency memory.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int NODE_W = 6;
  localparam int CNT_W = 7;
  localparam int NODE_LIMIT = 2 ** NODE_W;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } bfs_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] intermediate_count;
    logic              unreachable;
  } bfs_res_t;

  // Commands to the adjacency memory; at most one is set in a cycle.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } adj_cmd_t;

endpackage

>>> src/bfs_adj_mem.sv
// ----------------------------------------------------------------------------
// bfs_adj_mem: adjacency matrix storage
// One row per node in a synchronous memory with a registered read. A valid
// bit per row lets a graph clear take effect at once; invalid rows read zero.
// ----------------------------------------------------------------------------
module bfs_adj_mem #(
  parameter int N  = 64,
  parameter int AW = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfs_pkg::adj_cmd_t  cmd_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [N-1:0]       wdata_i,
  output logic [N-1:0]       rdata_o
);
  import bfs_pkg::*;

  logic [N-1:0] mem [N];
  logic [N-1:0] rdata_q;
  logic [N-1:0] row_valid_q;
  logic         rvalid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        row_valid_q <= '0;
      end else if (cmd_i.wr) begin
        row_valid_q[addr_i] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rvalid_q <= row_valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

>>> src/bfs_shortest_hop_count_top.sv
// ----------------------------------------------------------------------------
// bfs_shortest_hop_count_top: shortest hop count by breadth-first search
// Keeps an undirected graph in an adjacency memory and answers hop count
// queries with a search FIFO held in a second memory.
// ----------------------------------------------------------------------------
// Usage: a request on req_i is taken at a clock edge where start is high and
// busy is low. A clear request gives no result and does not raise busy. An
// add request updates both rows of the edge by read-modify-write (S_ADD_RA,
// S_ADD_WA, S_ADD_RB, S_ADD_WB) and gives no result. A query gives one result
// on res_o, marked by done_o for exactly one cycle; the receiver cannot hold
// it off. A query whose source equals its destination or is out of range is
// answered straight from idle. Otherwise each popped node that is not the
// destination passes S_POP (FIFO read), S_LOAD (row read), S_ROW (row capture)
// and S_SCAN, which pushes its pending neighbors one at a time and then goes
// back to S_POP; the search ends in S_POP on an empty FIFO or in S_LOAD on a
// match. The single read port of each memory sets this order of steps.
// done_o is high in the first cycle that busy is low again, so the next
// request can be taken in that cycle.
// node_count is written through cfg_we_i/cfg_wdata_i; write it only while the
// block is idle, which the block itself does not enforce.
// Reset empties the graph, sets node_count to 64 and returns to idle.
// ----------------------------------------------------------------------------
module bfs_shortest_hop_count_top #(
  parameter int MAX_NODES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  bfs_pkg::bfs_req_t          req_i,
  output logic                       done_o,
  output bfs_pkg::bfs_res_t          res_o,
  input  logic                       cfg_we_i,
  input  logic [bfs_pkg::CNT_W-1:0]  cfg_wdata_i
);
  import bfs_pkg::*;

  // Only nodes that fit the request fields can ever carry edges.
  localparam int NODES = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
  localparam int AW = $clog2(NODES);
  localparam int PW = $clog2(NODES + 1);
  localparam int FW = NODE_W + AW;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ADD_RA = 9'b000000010,
    S_ADD_WA = 9'b000000100,
    S_ADD_RB = 9'b000001000,
    S_ADD_WB = 9'b000010000,
    S_POP    = 9'b000100000,
    S_LOAD   = 9'b001000000,
    S_ROW    = 9'b010000000,
    S_SCAN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  node_count_q;
  logic [NODE_W-1:0] a_q, a_d;
  logic [NODE_W-1:0] b_q, b_d;
  logic [NODES-1:0]  visited_q, visited_d;
  logic [NODES-1:0]  cand_q, cand_d;
  logic [NODE_W-1:0] len_q, len_d;
  logic [PW-1:0]     head_q, head_d;
  logic [PW-1:0]     tail_q, tail_d;
  logic              done_q, done_d;
  bfs_res_t          res_q, res_d;

  adj_cmd_t          adj_cmd;
  logic [AW-1:0]     adj_addr;
  logic [NODES-1:0]  adj_wdata;
  logic [NODES-1:0]  adj_rdata;

  logic [FW-1:0]     fifo_mem [NODES];
  logic [FW-1:0]     fifo_rdata_q;
  logic              fifo_we;
  logic              fifo_re;
  logic [AW-1:0]     fifo_waddr;
  logic [FW-1:0]     fifo_wdata;

  logic [NODES-1:0]  lim_mask;
  logic [AW-1:0]     pick;
  logic [AW-1:0]     pop_node;
  logic [NODE_W-1:0] pop_len;
  logic              accept;

  assign accept   = start && !busy;
  assign busy     = (state_q != S_IDLE);
  assign pop_node = fifo_rdata_q[AW-1:0];
  assign pop_len  = fifo_rdata_q[FW-1:AW];

  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      lim_mask[j] = (CNT_W'(j) < node_count_q);
    end
  end

  // Lowest pending neighbor goes into the FIFO first, as in a plain scan.
  always_comb begin
    pick = '0;
    for (int j = NODES - 1; j >= 0; j--) begin
      if (cand_q[j]) begin
        pick = AW'(j);
      end
    end
  end

  bfs_adj_mem #(
    .N  (NODES),
    .AW (AW)
  ) u_adj_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (adj_cmd),
    .addr_i  (adj_addr),
    .wdata_i (adj_wdata),
    .rdata_o (adj_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    if (fifo_re) begin
      fifo_rdata_q <= fifo_mem[head_q[AW-1:0]];
    end
  end

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    visited_d  = visited_q;
    cand_d     = cand_q;
    len_d      = len_q;
    head_d     = head_q;
    tail_d     = tail_q;
    done_d     = 1'b0;
    res_d      = res_q;
    adj_cmd    = '0;
    adj_addr   = '0;
    adj_wdata  = '0;
    fifo_we    = 1'b0;
    fifo_re    = 1'b0;
    fifo_waddr = '0;
    fifo_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          a_d = req_i.node_a;
          b_d = req_i.node_b;
          unique case (req_i.op)
            OP_CLEAR: begin
              adj_cmd.clr = 1'b1;
              visited_d   = '0;
            end
            OP_ADD: begin
              if (int'(req_i.node_a) < NODES && int'(req_i.node_b) < NODES) begin
                state_d = S_ADD_RA;
              end
            end
            OP_QUERY: begin
              if (req_i.node_a == req_i.node_b) begin
                done_d = 1'b1;
                res_d  = '{intermediate_count: '0, unreachable: 1'b0};
              end else if (int'(req_i.node_a) >= NODES) begin
                done_d = 1'b1;
                res_d  = '{intermediate_count: '0, unreachable: 1'b1};
              end else begin
                visited_d = '0;
                visited_d[req_i.node_a[AW-1:0]] = 1'b1;
                fifo_we    = 1'b1;
                fifo_waddr = '0;
                fifo_wdata = {NODE_W'(0), req_i.node_a[AW-1:0]};
                head_d     = '0;
                tail_d     = PW'(1);
                state_d    = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD_RA: begin
        adj_cmd.rd = 1'b1;
        adj_addr   = a_q[AW-1:0];
        state_d    = S_ADD_WA;
      end
      S_ADD_WA: begin
        adj_cmd.wr = 1'b1;
        adj_addr   = a_q[AW-1:0];
        adj_wdata  = adj_rdata | (NODES'(1) << b_q[AW-1:0]);
        state_d    = S_ADD_RB;
      end
      S_ADD_RB: begin
        adj_cmd.rd = 1'b1;
        adj_addr   = b_q[AW-1:0];
        state_d    = S_ADD_WB;
      end
      S_ADD_WB: begin
        adj_cmd.wr = 1'b1;
        adj_addr   = b_q[AW-1:0];
        adj_wdata  = adj_rdata | (NODES'(1) << a_q[AW-1:0]);
        state_d    = S_IDLE;
      end
      S_POP: begin
        if (head_q == tail_q) begin
          done_d  = 1'b1;
          res_d   = '{intermediate_count: '0, unreachable: 1'b1};
          state_d = S_IDLE;
        end else begin
          fifo_re = 1'b1;
          head_d  = head_q + PW'(1);
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (NODE_W'(pop_node) == b_q) begin
          // Source differs from destination, so the hop length is at least one.
          done_d  = 1'b1;
          res_d   = '{intermediate_count: pop_len - NODE_W'(1), unreachable: 1'b0};
          state_d = S_IDLE;
        end else begin
          adj_cmd.rd = 1'b1;
          adj_addr   = pop_node;
          len_d      = pop_len;
          state_d    = S_ROW;
        end
      end
      S_ROW: begin
        cand_d  = adj_rdata & ~visited_q & lim_mask;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cand_q == '0) begin
          state_d = S_POP;
        end else begin
          fifo_we        = 1'b1;
          fifo_waddr     = tail_q[AW-1:0];
          fifo_wdata     = {len_q + NODE_W'(1), pick};
          tail_d         = tail_q + PW'(1);
          visited_d[pick] = 1'b1;
          cand_d[pick]   = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= NODE_COUNT_RST;
      visited_q    <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    cand_q <= cand_d;
    len_q  <= len_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // The result strobe only follows a finished request, with the block idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a request is in progress");

  a_fifo_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (int'(tail_q) <= NODES))
    else $error("search FIFO pointers out of order");

  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.unreachable) |-> (res_o.intermediate_count == '0))
    else $error("unreachable result carries a nonzero count");

  a_scan_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ((cand_q & visited_q) == '0))
    else $error("candidate neighbor already visited");

endmodule

>>> dv/hop_count_sb_pkg.sv
// ----------------------------------------------------------------------------
// hop_count_sb_pkg: scoreboard for the shortest hop count block
// Mirrors the adjacency matrix and node_count setting, predicts the answer
// of each accepted query by its own breadth-first search and compares the
// answers that come back, in order, field by field.
// ----------------------------------------------------------------------------
package hop_count_sb_pkg;

  import bfs_pkg::*;

  class hop_count_scoreboard;

    logic [NODE_LIMIT-1:0] adj_rows [NODE_LIMIT];
    logic [CNT_W-1:0]      node_count;
    bfs_res_t              expected_hops [$];
    int                    failures;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      node_count = NODE_COUNT_RST;
      failures = 0;
    endfunction

    function void set_node_count(logic [CNT_W-1:0] value);
      node_count = value;
    endfunction

    function int pending();
      return expected_hops.size();
    endfunction

    function bfs_res_t shortest_hops(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
      bfs_res_t          res;
      logic [NODE_LIMIT-1:0] seen;
      logic [NODE_W-1:0] ring_node [NODE_LIMIT];
      int unsigned       ring_len [NODE_LIMIT];
      int unsigned       head;
      int unsigned       tail;
      int unsigned       scan_lim;
      int unsigned       hops;
      logic [NODE_W-1:0] v;
      res = '0;
      if (src == dst) return res;
      scan_lim = (node_count > NODE_LIMIT) ? NODE_LIMIT : node_count;
      seen = '0;
      seen[src] = 1'b1;
      ring_node[0] = src;
      ring_len[0] = 0;
      head = 0;
      tail = 1;
      while (head < tail) begin
        v = ring_node[head];
        hops = ring_len[head];
        head++;
        if (v == dst) begin
          res.intermediate_count = (hops - 1 > 63) ? 6'd63 : NODE_W'(hops - 1);
          return res;
        end
        for (int j = 0; j < scan_lim; j++) begin
          if (adj_rows[v][j] && !seen[j] && tail < NODE_LIMIT) begin
            ring_node[tail] = NODE_W'(j);
            ring_len[tail] = hops + 1;
            tail++;
            seen[j] = 1'b1;
          end
        end
      end
      res.unreachable = 1'b1;
      return res;
    endfunction

    function void note_request(bfs_req_t req);
      case (req.op)
        OP_CLEAR: foreach (adj_rows[i]) adj_rows[i] = '0;
        OP_ADD: begin
          adj_rows[req.node_a][req.node_b] = 1'b1;
          adj_rows[req.node_b][req.node_a] = 1'b1;
        end
        OP_QUERY: expected_hops.push_back(shortest_hops(req.node_a, req.node_b));
        default: ;  // the unused code leaves everything as it is
      endcase
    endfunction

    function void check_result(bfs_res_t got);
      bfs_res_t want;
      if (expected_hops.size() == 0) begin
        failures++;
        $display("%0t: result with no query waiting: expected none, got count=%0d unreachable=%0b",
                 $time, got.intermediate_count, got.unreachable);
        return;
      end
      want = expected_hops.pop_front();
      if (got.intermediate_count !== want.intermediate_count) begin
        failures++;
        $display("%0t: intermediate_count mismatch: expected %0d, got %0d",
                 $time, want.intermediate_count, got.intermediate_count);
      end
      if (got.unreachable !== want.unreachable) begin
        failures++;
        $display("%0t: unreachable mismatch: expected %0b, got %0b",
                 $time, want.unreachable, got.unreachable);
      end
    endfunction

  endclass

endpackage

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the shortest hop count block
// Sends clear, add and query requests, first a directed set and then random
// graphs, chains and noise under several node_count settings and sender idle
// rates, and checks every query answer against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

  import bfs_pkg::*;
  import hop_count_sb_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  bfs_req_t         req_i;
  logic             done_o;
  bfs_res_t         res_o;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  hop_count_scoreboard hop_sb;
  int                  idle_pct;
  int                  sent_count;
  logic [CNT_W-1:0]    cur_count;
  int                  order [NODE_LIMIT];

  logic [CNT_W-1:0] count_plan [8] = '{7'd1, 7'd127, 7'd64, 7'd0, 7'd40, 7'd64, 7'd9, 7'd64};
  int               idle_plan [4] = '{0, 62, 0, 22};

  bfs_shortest_hop_count_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10000000;
    $display("Test completed with failures");
    $finish;
  end

  // Results are checked before the request of the same edge is noted, so a
  // query taken in the cycle of an earlier answer never matches it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) hop_sb.check_result(res_o);
      if (start && !busy) hop_sb.note_request(req_i);
      if (cfg_we_i) hop_sb.set_node_count(cfg_wdata_i);
    end
  end

  task automatic send_request(op_e op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= '{op: op, node_a: a, node_b: b};
    do @(posedge clk_i); while (busy);
    sent_count++;
  endtask

  task automatic wait_idle(int extra);
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (hop_sb.pending() != 0 || busy);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [CNT_W-1:0] value);
    // Adds give no answer, so the wait runs on until busy is low as well.
    wait_idle(16);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_count = value;
  endtask

  function automatic logic [NODE_W-1:0] pick_node(int span);
    if ($urandom_range(0, 9) == 0) return NODE_W'($urandom);
    return NODE_W'($urandom_range(0, span - 1));
  endfunction

  initial begin
    int phase_goal;
    int kind;
    int span;
    int sub;
    int len;
    int x;
    int y;
    int tmp;
    hop_sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    idle_pct = 0;
    sent_count = 0;
    cur_count = NODE_COUNT_RST;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    write_node_count(NODE_COUNT_RST);
    send_request(OP_QUERY, 6'd5, 6'd5);
    send_request(OP_QUERY, 6'd0, 6'd63);
    send_request(op_e'(2'd3), 6'd63, 6'd63);
    send_request(OP_ADD, 6'd0, 6'd1);
    send_request(OP_ADD, 6'd2, 6'd1);
    send_request(OP_ADD, 6'd2, 6'd63);
    send_request(OP_ADD, 6'd63, 6'd63);
    send_request(OP_ADD, 6'd5, 6'd5);
    send_request(OP_QUERY, 6'd0, 6'd63);
    send_request(OP_QUERY, 6'd63, 6'd0);
    send_request(OP_QUERY, 6'd0, 6'd1);
    send_request(OP_QUERY, 6'd5, 6'd6);
    send_request(OP_QUERY, 6'd63, 6'd63);
    send_request(op_e'(2'd3), 6'd0, 6'd0);
    send_request(OP_QUERY, 6'd1, 6'd63);
    send_request(OP_CLEAR, 6'd0, 6'd0);
    send_request(OP_QUERY, 6'd0, 6'd1);
    send_request(OP_ADD, 6'd62, 6'd61);
    send_request(OP_QUERY, 6'd61, 6'd62);
    send_request(OP_QUERY, 6'd42, 6'd21);

    for (int phase = 0; phase < 8; phase++) begin
      write_node_count(count_plan[phase]);
      idle_pct = idle_plan[phase % 4];
      phase_goal = sent_count + 100;
      while (sent_count < phase_goal) begin
        span = (cur_count >= 2 && cur_count <= NODE_LIMIT && $urandom_range(0, 3) != 0)
               ? int'(cur_count) : NODE_LIMIT;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
          // Random sparse graph among the low nodes.
          if ($urandom_range(0, 9) != 0) send_request(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
          sub = $urandom_range(2, span);
          repeat ($urandom_range(1, 14)) send_request(OP_ADD, pick_node(sub), pick_node(sub));
          repeat ($urandom_range(1, 6)) send_request(OP_QUERY, pick_node(sub), pick_node(sub));
        end else if (kind <= 6) begin
          // A chain through shuffled nodes gives long shortest paths.
          if ($urandom_range(0, 9) != 0) send_request(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
          for (int i = 0; i < NODE_LIMIT; i++) order[i] = i;
          for (int i = span - 1; i > 0; i--) begin
            x = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[x];
            order[x] = tmp;
          end
          len = ($urandom_range(0, 19) == 0) ? span : $urandom_range(2, (span < 20) ? span : 20);
          for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 1) != 0)
              send_request(OP_ADD, NODE_W'(order[i-1]), NODE_W'(order[i]));
            else send_request(OP_ADD, NODE_W'(order[i]), NODE_W'(order[i-1]));
          end
          if ($urandom_range(0, 1) != 0)
            send_request(OP_ADD, NODE_W'(order[$urandom_range(0, len-1)]),
                         NODE_W'(order[$urandom_range(0, len-1)]));
          send_request(OP_QUERY, NODE_W'(order[0]), NODE_W'(order[len-1]));
          repeat ($urandom_range(1, 4)) begin
            x = $urandom_range(0, len - 1);
            y = $urandom_range(0, len - 1);
            send_request(OP_QUERY, NODE_W'(order[x]), NODE_W'(order[y]));
          end
        end else if (kind == 7) begin
          repeat ($urandom_range(1, 6))
            send_request(op_e'($urandom_range(0, 3)), NODE_W'($urandom), NODE_W'($urandom));
        end else begin
          // Grow the graph that is already there.
          repeat ($urandom_range(1, 4)) send_request(OP_ADD, pick_node(span), pick_node(span));
          repeat ($urandom_range(1, 4)) send_request(OP_QUERY, pick_node(span), pick_node(span));
        end
        if ($urandom_range(0, 29) == 0) wait_idle(0);
      end
    end

    wait_idle(300);
    if (hop_sb.failures == 0 && hop_sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bfs_pkg.sv
src/bfs_adj_mem.sv
src/bfs_shortest_hop_count_top.sv
dv/hop_count_sb_pkg.sv
dv/testbench.sv
